// ----- design/prdl_pkg.sv -----
// prdl_pkg: shared types and constants for the Pollard rho discrete-log block.
// Used by prdl_ctrl, prdl_datapath and the top level. No dependencies.
`default_nettype none

package prdl_pkg;

    // Width of group elements (modulus, generator, target, start x)
    localparam int MOD_BITS = 16;
    localparam int FIELD_W  = 16;

    localparam logic [FIELD_W-1:0] ELEM_MASK = (MOD_BITS >= FIELD_W) ?
        {FIELD_W{1'b1}} : FIELD_W'((64'd1 << MOD_BITS) - 64'd1);

    // One walk step: serial multiply and serial reductions, one bit per cycle
    localparam int WALK_STEPS = FIELD_W + 1;
    localparam int STEP_W     = $clog2(WALK_STEPS);

    localparam int S_TDATA_W = 3 * FIELD_W;
    localparam int M_TDATA_W = 7 * FIELD_W;
    localparam int M_TUSER_W = 2;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODULUS   = 2'd0,
        REG_ORDER     = 2'd1,
        REG_GENERATOR = 2'd2,
        REG_TARGET    = 2'd3
    } cfg_reg_t;

    localparam logic [FIELD_W-1:0] RST_MODULUS   = 16'd127 & ELEM_MASK;
    localparam logic [FIELD_W-1:0] RST_ORDER     = 16'd126;
    localparam logic [FIELD_W-1:0] RST_GENERATOR = 16'd3 & ELEM_MASK;
    localparam logic [FIELD_W-1:0] RST_TARGET    = 16'd50 & ELEM_MASK;

    // Controller -> datapath
    typedef struct packed {
        logic load_in;     // capture start triple, clear flags and count
        logic walk_load;   // classify working triple, set up the serial units
        logic walk_step;   // one bit of multiply / reduce
        logic walk_store;  // write walk result back
        logic walk_fast;   // 1: walk the hare, 0: the tortoise
        logic iter_inc;
        logic set_bad;
        logic set_found;
        logic out_load;    // copy results into the output register
    } prdl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic bad_start;   // start x >= modulus
        logic more;        // iteration count + 1 < group order
        logic collide;     // tortoise x == hare x
    } prdl_status_t;

endpackage

`default_nettype wire

// ----- design/prdl_ctrl.sv -----
// prdl_ctrl: sequencing FSM for the rho walk (three walks per iteration).
// Depends on prdl_pkg.
`default_nettype none

module prdl_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire prdl_pkg::prdl_status_t status,
    output prdl_pkg::prdl_cmd_t         cmd
);
    import prdl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_RUN,
        ST_STORE,
        ST_ITER,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        walk_reg, walk_next;   // 0: tortoise, 1..2: hare
    logic              out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        walk_next  = walk_reg;
        cmd        = '0;
        cmd.walk_fast = (walk_reg != 2'd0);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                walk_next = 2'd0;
                if (status.bad_start)
                begin
                    cmd.set_bad = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (status.more)
                    state_next = ST_LOAD;
                else
                    state_next = ST_DONE;
            end
            ST_LOAD:
            begin
                cmd.walk_load = 1'b1;
                step_next     = '0;
                state_next    = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.walk_step = 1'b1;
                if (step_reg == STEP_W'(WALK_STEPS - 1))
                    state_next = ST_STORE;
                else
                    step_next = step_reg + STEP_W'(1);
            end
            ST_STORE:
            begin
                cmd.walk_store = 1'b1;
                if (walk_reg == 2'd2)
                begin
                    cmd.iter_inc = 1'b1;
                    state_next   = ST_ITER;
                end
                else
                begin
                    walk_next  = walk_reg + 2'd1;
                    state_next = ST_LOAD;
                end
            end
            ST_ITER:
            begin
                walk_next = 2'd0;
                if (status.collide)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = ST_DONE;
                end
                else if (status.more)
                    state_next = ST_LOAD;
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // wait until the output register is free or being emptied
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/prdl_datapath.sv -----
// prdl_datapath: config registers, tortoise/hare triples, bit-serial modular
// multiplier and exponent reducers, output register. Depends on prdl_pkg.
`default_nettype none

module prdl_datapath (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [15:0]              cfg_wdata,
    input  wire logic [47:0]              s_tdata,
    input  wire prdl_pkg::prdl_cmd_t      cmd,
    output prdl_pkg::prdl_status_t        status,
    output logic [111:0]                  m_tdata,
    output logic [1:0]                    m_tuser
);
    import prdl_pkg::*;

    localparam int W = FIELD_W;

    // x mod 3: 4 == 1 mod 3, so sum base-4 digits and fold
    function automatic logic [1:0] mod3(input logic [W-1:0] v);
        logic [5:0] s;
        logic [2:0] t;
        s = '0;
        for (int i = 0; i < W / 2; i++)
            s = s + {4'd0, v[2*i +: 2]};
        t = {1'b0, s[1:0]} + {1'b0, s[3:2]} + {1'b0, s[5:4]};
        if (t >= 3'd6)
            t = t - 3'd6;
        else if (t >= 3'd3)
            t = t - 3'd3;
        return t[1:0];
    endfunction

    // one restoring-remainder step: shift in a dividend bit, subtract once
    function automatic logic [W-1:0] red_step(input logic [W-1:0] rem,
                                              input logic bit_in,
                                              input logic [W-1:0] divisor);
        logic [W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, divisor})
            t = t - {1'b0, divisor};
        return t[W-1:0];
    endfunction

    logic [W-1:0] modulus_reg, order_reg, gen_reg, tgt_reg;

    logic [W-1:0] sx_reg, sa_reg, sb_reg, fx_reg, fa_reg, fb_reg;
    logic [W-1:0] iter_reg;
    logic         found_reg, bad_reg;

    // walk working set
    logic [1:0]   cls_reg;
    logic [W-1:0] mcand_reg, acc_reg, keep_a_reg, keep_b_reg, rem_a_reg, rem_b_reg;
    logic [W:0]   mplier_reg, div_a_reg, div_b_reg;

    logic [W-1:0] out_iter_reg, out_sx_reg, out_sa_reg, out_sb_reg;
    logic [W-1:0] out_fx_reg, out_fa_reg, out_fb_reg;
    logic         out_found_reg, out_bad_reg;

    logic [W-1:0] cur_x, cur_a, cur_b;
    logic [1:0]   cur_cls;
    logic [W:0]   dbl, sum;
    logic [W-1:0] dbl_red, acc_next;
    logic [W-1:0] new_a, new_b;
    logic [W:0]   iter_p1;

    assign cur_x   = cmd.walk_fast ? fx_reg : sx_reg;
    assign cur_a   = cmd.walk_fast ? fa_reg : sa_reg;
    assign cur_b   = cmd.walk_fast ? fb_reg : sb_reg;
    assign cur_cls = mod3(cur_x);

    // multiplier step: acc = 2*acc mod m, then + mcand mod m if bit set
    always_comb
    begin
        dbl = {acc_reg, 1'b0};
        if (dbl >= {1'b0, modulus_reg})
            dbl = dbl - {1'b0, modulus_reg};
        dbl_red = dbl[W-1:0];
        sum = {1'b0, dbl_red} + {1'b0, mcand_reg};
        if (sum >= {1'b0, modulus_reg})
            sum = sum - {1'b0, modulus_reg};
        acc_next = mplier_reg[W] ? sum[W-1:0] : dbl_red;
    end

    // class 1 leaves b untouched, class 2 leaves a untouched
    assign new_a = (cls_reg == 2'd2) ? keep_a_reg : rem_a_reg;
    assign new_b = (cls_reg == 2'd1) ? keep_b_reg : rem_b_reg;

    assign iter_p1          = {1'b0, iter_reg} + {{W{1'b0}}, 1'b1};
    assign status.more      = iter_p1 < {1'b0, order_reg};
    assign status.collide   = (sx_reg == fx_reg);
    assign status.bad_start = (sx_reg >= modulus_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= RST_MODULUS;
            order_reg   <= RST_ORDER;
            gen_reg     <= RST_GENERATOR;
            tgt_reg     <= RST_TARGET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MODULUS:   modulus_reg <= cfg_wdata & ELEM_MASK;
                REG_ORDER:     order_reg   <= cfg_wdata;
                REG_GENERATOR: gen_reg     <= cfg_wdata & ELEM_MASK;
                REG_TARGET:    tgt_reg     <= cfg_wdata & ELEM_MASK;
                default:       modulus_reg <= modulus_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            bad_reg   <= 1'b0;
            iter_reg  <= '0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                found_reg <= 1'b0;
                bad_reg   <= 1'b0;
                iter_reg  <= '0;
            end
            if (cmd.set_bad)
                bad_reg <= 1'b1;
            if (cmd.set_found)
                found_reg <= 1'b1;
            if (cmd.iter_inc)
                iter_reg <= iter_p1[W-1:0];
        end
    end

    // triples and serial units (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sx_reg <= s_tdata[W-1:0] & ELEM_MASK;
            sa_reg <= s_tdata[2*W-1:W];
            sb_reg <= s_tdata[3*W-1:2*W];
            fx_reg <= s_tdata[W-1:0] & ELEM_MASK;
            fa_reg <= s_tdata[2*W-1:W];
            fb_reg <= s_tdata[3*W-1:2*W];
        end
        else if (cmd.walk_store)
        begin
            if (cmd.walk_fast)
            begin
                fx_reg <= acc_reg;
                fa_reg <= new_a;
                fb_reg <= new_b;
            end
            else
            begin
                sx_reg <= acc_reg;
                sa_reg <= new_a;
                sb_reg <= new_b;
            end
        end

        if (cmd.walk_load)
        begin
            cls_reg    <= cur_cls;
            mcand_reg  <= cur_x;
            acc_reg    <= '0;
            keep_a_reg <= cur_a;
            keep_b_reg <= cur_b;
            rem_a_reg  <= '0;
            rem_b_reg  <= '0;
            case (cur_cls)
                2'd0:
                begin
                    mplier_reg <= {1'b0, cur_x};
                    div_a_reg  <= {cur_a, 1'b0};
                    div_b_reg  <= {cur_b, 1'b0};
                end
                2'd1:
                begin
                    mplier_reg <= {1'b0, gen_reg};
                    div_a_reg  <= {1'b0, cur_a} + {{W{1'b0}}, 1'b1};
                    div_b_reg  <= {1'b0, cur_b};
                end
                default:
                begin
                    mplier_reg <= {1'b0, tgt_reg};
                    div_a_reg  <= {1'b0, cur_a};
                    div_b_reg  <= {1'b0, cur_b} + {{W{1'b0}}, 1'b1};
                end
            endcase
        end
        else if (cmd.walk_step)
        begin
            acc_reg    <= acc_next;
            mplier_reg <= {mplier_reg[W-1:0], 1'b0};
            rem_a_reg  <= red_step(rem_a_reg, div_a_reg[W], order_reg);
            rem_b_reg  <= red_step(rem_b_reg, div_b_reg[W], order_reg);
            div_a_reg  <= {div_a_reg[W-1:0], 1'b0};
            div_b_reg  <= {div_b_reg[W-1:0], 1'b0};
        end

        if (cmd.out_load)
        begin
            out_found_reg <= found_reg;
            out_bad_reg   <= bad_reg;
            out_iter_reg  <= iter_reg;
            out_sx_reg    <= sx_reg;
            out_sa_reg    <= sa_reg;
            out_sb_reg    <= sb_reg;
            out_fx_reg    <= fx_reg;
            out_fa_reg    <= fa_reg;
            out_fb_reg    <= fb_reg;
        end
    end

    assign m_tdata = {out_fb_reg, out_fa_reg, out_fx_reg,
                      out_sb_reg, out_sa_reg, out_sx_reg, out_iter_reg};
    assign m_tuser = {out_bad_reg, out_found_reg};

endmodule

`default_nettype wire

// ----- design/pollard_rho_dlog_collision_top.sv -----
// Pollard rho discrete-log collision search, top level.
// Each iteration runs three walks (setup, serial bit steps, write) and then the
//   collision and limit check; a bad start or group order <= 1 runs none.
// A new start triple is accepted only after the previous run hands its result to the output register.
// Reset (async, active low): config registers return to 127 / 126 / 3 / 50, FSM idle.
`default_nettype none

module pollard_rho_dlog_collision_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // config write port: 0 modulus, 1 group_order, 2 generator, 3 target
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_wdata,
    // input beat
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [47:0]   s_tdata,   // start_x, start_a, start_b
    // result beat
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [111:0]       m_tdata,   // iterations, slow_x, slow_a, slow_b,
                                          // fast_x, fast_a, fast_b
    output logic [1:0]         m_tuser    // found, bad_start
);
    import prdl_pkg::*;

    prdl_cmd_t    cmd;
    prdl_status_t status;

    // Controller: accept beat, bad-start / order check, three walks per
    // iteration (tortoise once, hare twice), collision and limit check,
    // then hand the result to the output register. The output register
    // holds a finished beat while the next start triple is accepted.
    prdl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: config registers, both triples, serial x*y mod m with
    // the exponent reductions mod group order running alongside.
    prdl_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ----- design/prdl_checker.sv -----
// prdl_checker: port-level assertions for the rho top level, bound to it.
// Depends on pollard_rho_dlog_collision_top port list only.
`default_nettype none

module prdl_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          m_tvalid,
    input  wire logic          m_tready,
    input  wire logic [111:0]  m_tdata,
    input  wire logic [1:0]    m_tuser
);

    // stalled result beat stays up
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // found and bad_start exclude each other
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("found and bad_start both set");

    // a collision means equal tortoise and hare elements
    a_found_x: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[31:16] == m_tdata[79:64])
        else $error("found without equal x");

    // no iteration run: both triples still the start triple
    a_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15:0] == 16'd0 |->
            m_tdata[63:16] == m_tdata[111:64] && !m_tuser[0])
        else $error("triples differ with zero iterations");

    // bad start reports zero iterations
    a_bad_iter: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[15:0] == 16'd0)
        else $error("bad start with nonzero iteration count");

endmodule

bind pollard_rho_dlog_collision_top prdl_checker u_prdl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
